[sv/drp_pkg.sv]
// shared types, constants and helpers for the dhcp reply parser
// no dependencies; the design files refer to this package by scoped names, the bench files import it
package drp_pkg;

    localparam int OPTION_AREA_BYTES = 312;
    localparam int HEADER_BYTES      = 240;
    localparam int MAX_PAYLOAD       = HEADER_BYTES + OPTION_AREA_BYTES;
    // position counter saturates at MAX_PAYLOAD + 1
    localparam int POS_W             = $clog2(MAX_PAYLOAD + 2);

    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
    localparam logic [31:0] XID_RESET    = 32'h4741_4C49;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_END    = 8'd255;
    localparam logic [7:0] TYPE_OFFER = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd5;

    localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_MAX        = POS_W'(MAX_PAYLOAD);
    localparam logic [POS_W-1:0] POS_XID_FIRST  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_XID_LAST   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_YI_FIRST   = POS_W'(16);
    localparam logic [POS_W-1:0] POS_YI_LAST    = POS_W'(19);
    localparam logic [POS_W-1:0] POS_CK_FIRST   = POS_W'(236);
    localparam logic [POS_W-1:0] POS_CK_LAST    = POS_W'(239);

    localparam int M_TDATA_BITS = 5 * 32 + 1;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_SIZE  = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_BAD_LENGTH = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_TRUNCATED  = 3'd2,
        ST_IGNORED    = 3'd3,
        ST_OFFER      = 3'd4,
        ST_BOUND      = 3'd5
    } status_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] offered;
        logic [31:0] leased;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] dns;
        logic        done;
    } result_t;

    // byte sel of a word in wire order, sel 0 is the most significant
    function automatic logic [7:0] wire_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0: b = w[31:24];
            2'd1: b = w[23:16];
            2'd2: b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

[sv/drp_in_reg.sv]
// input register of the dhcp reply parser: holds one accepted item
// depends on drp_pkg for the item struct
module drp_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  drp_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output drp_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    drp_pkg::in_item_t item_reg;
    logic              take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/drp_parser.sv]
// per-byte parse state of the dhcp reply parser: header checks, option walk,
// session state and the verdict on the last byte; depends on drp_pkg
module drp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [31:0]       cfg_data,
    input  logic              item_valid,
    input  drp_pkg::in_item_t item,
    input  logic              out_busy,
    output logic              advance,
    output logic              res_valid,
    output drp_pkg::result_t  res
);

    localparam int PW = drp_pkg::POS_W;

    logic [31:0]      xid_reg;
    logic             offer_seen_reg, offer_seen_next;
    logic             done_reg, done_next;
    logic [31:0]      dns_hold_reg, dns_hold_next;
    logic [31:0]      offer_hold_reg, offer_hold_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic             header_ok_reg, header_ok_next;
    logic [31:0]      yiaddr_reg, yiaddr_next;
    drp_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       size_reg, size_next;
    logic [31:0]      value_reg, value_next;
    logic [7:0]       msg_type_reg, msg_type_next;
    logic [31:0]      mask_reg, mask_next;
    logic [31:0]      gw_reg, gw_next;
    logic [31:0]      dns_pend_reg, dns_pend_next;
    logic             dns_pend_valid_reg, dns_pend_valid_next;
    logic             ended_reg, ended_next;

    logic             step;
    logic             finish;
    logic             truncated;
    logic             bad_len;
    logic [7:0]       b;
    logic [7:0]       consumed;

    // a last byte waits while the result register still holds an untaken result
    assign advance = !(item.last && !item.start && out_busy);
    assign step    = item_valid && advance;
    assign b       = item.data;

    always_comb begin
        offer_seen_next     = offer_seen_reg;
        done_next           = done_reg;
        dns_hold_next       = dns_hold_reg;
        offer_hold_next     = offer_hold_reg;
        pos_next            = pos_reg;
        header_ok_next      = header_ok_reg;
        yiaddr_next         = yiaddr_reg;
        phase_next          = phase_reg;
        code_next           = code_reg;
        left_next           = left_reg;
        size_next           = size_reg;
        value_next          = value_reg;
        msg_type_next       = msg_type_reg;
        mask_next           = mask_reg;
        gw_next             = gw_reg;
        dns_pend_next       = dns_pend_reg;
        dns_pend_valid_next = dns_pend_valid_reg;
        ended_next          = ended_reg;
        finish              = 1'b0;
        truncated           = 1'b0;
        bad_len             = 1'b0;
        consumed            = size_reg - left_reg;
        res_valid           = 1'b0;
        res.status          = drp_pkg::ST_IGNORED;
        res.offered         = offer_hold_reg;
        res.leased          = '0;
        res.mask            = '0;
        res.gateway         = '0;
        res.dns             = dns_hold_reg;
        res.done            = done_reg;

        if (step && !item.start) begin
            if (pos_reg < drp_pkg::POS_HEADER_END) begin
                if (pos_reg >= drp_pkg::POS_XID_FIRST && pos_reg <= drp_pkg::POS_XID_LAST) begin
                    if (b != drp_pkg::wire_byte(xid_reg, pos_reg[1:0])) begin
                        header_ok_next = 1'b0;
                    end
                end else if (pos_reg >= drp_pkg::POS_YI_FIRST
                             && pos_reg <= drp_pkg::POS_YI_LAST) begin
                    yiaddr_next = {yiaddr_reg[23:0], b};
                end else if (pos_reg >= drp_pkg::POS_CK_FIRST
                             && pos_reg <= drp_pkg::POS_CK_LAST) begin
                    if (b != drp_pkg::wire_byte(drp_pkg::MAGIC_COOKIE, pos_reg[1:0])) begin
                        header_ok_next = 1'b0;
                    end
                end
            end else if (pos_reg < drp_pkg::POS_MAX && !ended_reg) begin
                unique case (phase_reg)
                    drp_pkg::PH_CODE: begin
                        if (b == drp_pkg::OPT_END) begin
                            ended_next = 1'b1;
                        end else if (b != drp_pkg::OPT_PAD) begin
                            code_next  = b;
                            phase_next = drp_pkg::PH_SIZE;
                        end
                    end
                    drp_pkg::PH_SIZE: begin
                        size_next  = b;
                        left_next  = b;
                        value_next = '0;
                        if (b == 8'd0) begin
                            finish = 1'b1;
                        end else begin
                            phase_next = drp_pkg::PH_VALUE;
                        end
                    end
                    drp_pkg::PH_VALUE: begin
                        // only the first four value bytes are kept
                        if (consumed < 8'd4) begin
                            value_next = {value_reg[23:0], b};
                        end
                        left_next = left_reg - 8'd1;
                        if (left_next == 8'd0) begin
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = drp_pkg::PH_CODE;
                    end
                endcase
            end

            if (finish) begin
                if (code_next == drp_pkg::OPT_TYPE && size_next == 8'd1) begin
                    msg_type_next = value_next[7:0];
                end
                if (code_next == drp_pkg::OPT_DNS && size_next >= 8'd4) begin
                    dns_pend_next       = value_next;
                    dns_pend_valid_next = 1'b1;
                end
                if (code_next == drp_pkg::OPT_MASK && size_next == 8'd4) begin
                    mask_next = value_next;
                end
                if (code_next == drp_pkg::OPT_ROUTER && size_next >= 8'd4) begin
                    gw_next = value_next;
                end
                phase_next = drp_pkg::PH_CODE;
            end

            // saturates one past the largest legal length
            if (pos_reg <= drp_pkg::POS_MAX) begin
                pos_next = pos_reg + PW'(1);
            end

            if (item.last) begin
                res_valid = 1'b1;
                truncated = !ended_next && (phase_next != drp_pkg::PH_CODE);
                bad_len   = (pos_next < drp_pkg::POS_HEADER_END) || (pos_next > drp_pkg::POS_MAX);
                priority if (bad_len) begin
                    res.status = drp_pkg::ST_BAD_LENGTH;
                end else if (!header_ok_next) begin
                    res.status = drp_pkg::ST_BAD_HEADER;
                end else begin
                    if (dns_pend_valid_next) begin
                        dns_hold_next = dns_pend_next;
                    end
                    priority if (truncated) begin
                        res.status = drp_pkg::ST_TRUNCATED;
                    end else if (msg_type_next == drp_pkg::TYPE_OFFER && !offer_seen_reg) begin
                        offer_hold_next = yiaddr_next;
                        offer_seen_next = 1'b1;
                        res.status      = drp_pkg::ST_OFFER;
                    end else if (msg_type_next == drp_pkg::TYPE_ACK && offer_seen_reg) begin
                        res.leased  = yiaddr_next;
                        res.mask    = mask_next;
                        res.gateway = gw_next;
                        done_next   = 1'b1;
                        res.status  = drp_pkg::ST_BOUND;
                    end else begin
                        res.status = drp_pkg::ST_IGNORED;
                    end
                end
                res.offered = offer_hold_next;
                res.dns     = dns_hold_next;
                res.done    = done_next;
            end
        end

        if (step && item.start) begin
            offer_seen_next = 1'b0;
            done_next       = 1'b0;
            dns_hold_next   = '0;
            offer_hold_next = '0;
        end

        // per-packet state clears after every last byte and on a start item
        if (step && (item.start || item.last)) begin
            pos_next            = '0;
            header_ok_next      = 1'b1;
            yiaddr_next         = '0;
            phase_next          = drp_pkg::PH_CODE;
            code_next           = '0;
            left_next           = '0;
            size_next           = '0;
            value_next          = '0;
            msg_type_next       = '0;
            mask_next           = '0;
            gw_next             = '0;
            dns_pend_next       = '0;
            dns_pend_valid_next = 1'b0;
            ended_next          = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xid_reg            <= drp_pkg::XID_RESET;
            offer_seen_reg     <= 1'b0;
            done_reg           <= 1'b0;
            dns_hold_reg       <= '0;
            offer_hold_reg     <= '0;
            pos_reg            <= '0;
            header_ok_reg      <= 1'b1;
            yiaddr_reg         <= '0;
            phase_reg          <= drp_pkg::PH_CODE;
            code_reg           <= '0;
            left_reg           <= '0;
            size_reg           <= '0;
            value_reg          <= '0;
            msg_type_reg       <= '0;
            mask_reg           <= '0;
            gw_reg             <= '0;
            dns_pend_reg       <= '0;
            dns_pend_valid_reg <= 1'b0;
            ended_reg          <= 1'b0;
        end else begin
            if (cfg_valid) begin
                xid_reg <= cfg_data;
            end
            offer_seen_reg     <= offer_seen_next;
            done_reg           <= done_next;
            dns_hold_reg       <= dns_hold_next;
            offer_hold_reg     <= offer_hold_next;
            pos_reg            <= pos_next;
            header_ok_reg      <= header_ok_next;
            yiaddr_reg         <= yiaddr_next;
            phase_reg          <= phase_next;
            code_reg           <= code_next;
            left_reg           <= left_next;
            size_reg           <= size_next;
            value_reg          <= value_next;
            msg_type_reg       <= msg_type_next;
            mask_reg           <= mask_next;
            gw_reg             <= gw_next;
            dns_pend_reg       <= dns_pend_next;
            dns_pend_valid_reg <= dns_pend_valid_next;
            ended_reg          <= ended_next;
        end
    end

endmodule

[sv/drp_out_reg.sv]
// result register of the dhcp reply parser, holds one verdict until taken
// depends on drp_pkg for the result struct
module drp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  drp_pkg::result_t res_in,
    output logic             m_tvalid,
    input  logic             m_tready,
    output drp_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    drp_pkg::result_t res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

[sv/dhcp_reply_parser.sv]
// Takes one dhcp reply payload a byte per item and gives one verdict after the
// item marked tlast. An item passes an input register, then the parse logic,
// whose verdict lands in a result register, so a byte is accepted every cycle
// unless a last byte waits; m_tvalid rises when the result register loads. Only a
// last byte waits, and only while the result register still holds a verdict
// that has not been taken. A start item (s_tuser high) clears all exchange and payload state and
// gives no verdict. The transaction id register is written through the cfg
// channel, which is always ready; write it only while no payload is in flight.
module dhcp_reply_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // data_byte
    input  logic                            s_tuser,  // kind
    input  logic                            s_tlast,  // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // offered_address, leased_address, subnet_mask, gateway_address,
    // dns_server, lease_done, zero fill
    output logic [drp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [2:0]                      m_tuser,  // status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [31:0]                     cfg_data
);

    drp_pkg::in_item_t s_item;
    drp_pkg::in_item_t item;
    drp_pkg::result_t  res;
    drp_pkg::result_t  res_q;
    logic              item_valid;
    logic              advance;
    logic              res_valid;

    assign s_item.start = s_tuser;
    assign s_item.data  = s_tdata;
    assign s_item.last  = s_tlast;
    assign cfg_ready    = 1'b1;

    drp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    drp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_busy   (m_tvalid && !m_tready),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    drp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res_in   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_q)
    );

    assign m_tuser = res_q.status;
    assign m_tdata = {(drp_pkg::M_TDATA_W - drp_pkg::M_TDATA_BITS)'(0), res_q.done,
                      res_q.dns, res_q.gateway, res_q.mask, res_q.leased, res_q.offered};

endmodule

[sv/drp_checker.sv]
// port-level checks for dhcp_reply_parser, attached by the bind below
// depends on drp_pkg for the status codes
module drp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [drp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [2:0]                    m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= drp_pkg::ST_BOUND)
        else $error("status out of range");

    a_lease_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != drp_pkg::ST_BOUND |->
            m_tdata[63:32] == 32'd0 && m_tdata[95:64] == 32'd0 && m_tdata[127:96] == 32'd0)
        else $error("lease fields set without a bind");

    a_bound_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == drp_pkg::ST_BOUND |-> m_tdata[160])
        else $error("bound verdict without done flag");

endmodule

bind dhcp_reply_parser drp_checker u_drp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/dhcp_reply_checker.sv]
// result checker for the dhcp reply parser: tracks every accepted item, predicts
// the verdict of each payload and compares it with the result channel
// depends on drp_pkg for widths, option codes, phases and status values
module dhcp_reply_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // data_byte
    input  logic                          s_tuser,  // kind
    input  logic                          s_tlast,  // last_byte
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // offered_address, leased_address, subnet_mask, gateway_address,
    // dns_server, lease_done, zero fill
    input  logic [drp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [2:0]                    m_tuser,  // status
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [31:0]                   cfg_data,
    output int                            verdicts_due,
    output int                            fail_count
);
    import drp_pkg::*;

    logic [31:0] xid_reg;
    // exchange-wide state
    logic        offer_taken;
    logic        lease_bound;
    logic [31:0] dns_kept;
    logic [31:0] offer_addr;
    // per-payload state
    int unsigned pos;
    logic        hdr_good;
    logic [31:0] yiaddr_acc;
    phase_t      phase;
    logic [7:0]  opt_code;
    logic [7:0]  opt_size;
    logic [7:0]  opt_left;
    logic [31:0] opt_value;
    logic [7:0]  msg_type;
    logic [31:0] mask_seen;
    logic [31:0] router_seen;
    logic [31:0] dns_seen;
    logic        dns_seen_valid;
    logic        cut_short;
    logic        opts_done;

    result_t     verdict_q[$];
    result_t     want;
    int unsigned p;
    int          errors;

    initial begin
        errors = 0;
        verdicts_due = 0;
        fail_count = 0;
    end

    task automatic report_error(input string msg);
        if (errors < 50)
            $display("%0t: verdict mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic restart_payload();
        pos = 0;
        hdr_good = 1'b1;
        yiaddr_acc = '0;
        phase = PH_CODE;
        opt_code = '0;
        opt_size = '0;
        opt_left = '0;
        opt_value = '0;
        msg_type = '0;
        mask_seen = '0;
        router_seen = '0;
        dns_seen = '0;
        dns_seen_valid = 1'b0;
        cut_short = 1'b0;
        opts_done = 1'b0;
    endtask

    task automatic clear_exchange();
        offer_taken = 1'b0;
        lease_bound = 1'b0;
        dns_kept = '0;
        offer_addr = '0;
        restart_payload();
    endtask

    task automatic close_option();
        if (opt_code == OPT_TYPE && opt_size == 8'd1)
            msg_type = opt_value[7:0];
        if (opt_code == OPT_DNS && opt_size >= 8'd4) begin
            dns_seen = opt_value;
            dns_seen_valid = 1'b1;
        end
        if (opt_code == OPT_MASK && opt_size == 8'd4)
            mask_seen = opt_value;
        if (opt_code == OPT_ROUTER && opt_size >= 8'd4)
            router_seen = opt_value;
        phase = PH_CODE;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            xid_reg = XID_RESET;
            clear_exchange();
            verdict_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                xid_reg = cfg_data;

            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_error("verdict with none expected");
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tuser !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               m_tuser, want.status));
                    if (m_tdata[31:0] !== want.offered)
                        report_error($sformatf("offered_address %h, expected %h",
                                               m_tdata[31:0], want.offered));
                    if (m_tdata[63:32] !== want.leased)
                        report_error($sformatf("leased_address %h, expected %h",
                                               m_tdata[63:32], want.leased));
                    if (m_tdata[95:64] !== want.mask)
                        report_error($sformatf("subnet_mask %h, expected %h",
                                               m_tdata[95:64], want.mask));
                    if (m_tdata[127:96] !== want.gateway)
                        report_error($sformatf("gateway_address %h, expected %h",
                                               m_tdata[127:96], want.gateway));
                    if (m_tdata[159:128] !== want.dns)
                        report_error($sformatf("dns_server %h, expected %h",
                                               m_tdata[159:128], want.dns));
                    if (m_tdata[160] !== want.done)
                        report_error($sformatf("lease_done %b, expected %b",
                                               m_tdata[160], want.done));
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    // start item: new exchange, no verdict
                    clear_exchange();
                end else begin
                    p = pos;
                    if (p < HEADER_BYTES) begin
                        if (p >= 4 && p <= 7) begin
                            if (s_tdata != 8'(xid_reg >> (8 * (7 - p))))
                                hdr_good = 1'b0;
                        end else if (p >= 16 && p <= 19) begin
                            yiaddr_acc = {yiaddr_acc[23:0], s_tdata};
                        end else if (p >= HEADER_BYTES - 4) begin
                            if (s_tdata != 8'(MAGIC_COOKIE >> (8 * (HEADER_BYTES - 1 - p))))
                                hdr_good = 1'b0;
                        end
                    end else if (p < MAX_PAYLOAD && !opts_done) begin
                        case (phase)
                            PH_CODE: begin
                                if (s_tdata == OPT_END) begin
                                    opts_done = 1'b1;
                                end else if (s_tdata != OPT_PAD) begin
                                    opt_code = s_tdata;
                                    phase = PH_SIZE;
                                end
                            end
                            PH_SIZE: begin
                                opt_size = s_tdata;
                                opt_left = s_tdata;
                                opt_value = '0;
                                if (s_tdata == 8'd0)
                                    close_option();
                                else
                                    phase = PH_VALUE;
                            end
                            default: begin
                                // only the first four value bytes are kept
                                if (8'(opt_size - opt_left) < 8'd4)
                                    opt_value = {opt_value[23:0], s_tdata};
                                opt_left = opt_left - 8'd1;
                                if (opt_left == 8'd0)
                                    close_option();
                            end
                        endcase
                    end
                    // the count saturates one past the longest payload
                    if (p <= MAX_PAYLOAD)
                        pos = p + 1;

                    if (s_tlast) begin
                        if (!opts_done && phase != PH_CODE)
                            cut_short = 1'b1;
                        want = '0;
                        if (pos < HEADER_BYTES || pos > MAX_PAYLOAD) begin
                            want.status = ST_BAD_LENGTH;
                        end else if (!hdr_good) begin
                            want.status = ST_BAD_HEADER;
                        end else begin
                            if (dns_seen_valid)
                                dns_kept = dns_seen;
                            if (cut_short) begin
                                want.status = ST_TRUNCATED;
                            end else if (msg_type == TYPE_OFFER && !offer_taken) begin
                                offer_addr = yiaddr_acc;
                                offer_taken = 1'b1;
                                want.status = ST_OFFER;
                            end else if (msg_type == TYPE_ACK && offer_taken) begin
                                want.leased = yiaddr_acc;
                                want.mask = mask_seen;
                                want.gateway = router_seen;
                                lease_bound = 1'b1;
                                want.status = ST_BOUND;
                            end else begin
                                want.status = ST_IGNORED;
                            end
                        end
                        want.offered = offer_addr;
                        want.dns = dns_kept;
                        want.done = lease_bound;
                        verdict_q.push_back(want);
                        restart_payload();
                    end
                end
            end
        end
        verdicts_due <= verdict_q.size();
        fail_count <= errors;
    end

endmodule

[verif/dhcp_reply_parser_test.sv]
// top of the dhcp reply parser test: clock, reset, payload stimulus, result-side
// stalls and the final verdict; depends on drp_pkg, dhcp_reply_parser and
// dhcp_reply_checker, which predicts and compares every verdict
module dhcp_reply_parser_test;
    import drp_pkg::*;

    localparam int   LIMIT_CYCLES = 400000;
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_START   = 1'b1;
    localparam int   FAULT_NONE   = 0;
    localparam int   FAULT_XID    = 1;
    localparam int   FAULT_COOKIE = 2;
    localparam int   READY_ALWAYS = 0;
    localparam int   READY_HALF   = 1;
    localparam int   READY_RARE   = 2;
    localparam int   HOLD_CYCLES  = 400;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;  // data_byte
    logic                   s_tuser = 1'b0;  // kind
    logic                   s_tlast = 1'b0;  // last_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // offered_address, leased_address, subnet_mask, gateway_address,
    // dns_server, lease_done, zero fill
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [2:0]             m_tuser;  // status
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [31:0]            cfg_data = '0;

    int          verdicts_due;
    int          fail_count;
    int unsigned cycle_count = 0;
    int          hold_off_asked = 0;
    int          hold_off_served = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          replies_sent = 0;
    logic [31:0] xid_now = XID_RESET;
    logic [7:0]  reply[$];

    dhcp_reply_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dhcp_reply_checker i_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .verdicts_due (verdicts_due),
        .fail_count   (fail_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random ready pattern in segments, plus a long hold-off on request
    initial begin : result_sink
        int seg;
        int mode;
        @(posedge aresetn);
        forever begin
            if (hold_off_asked != hold_off_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_served = hold_off_asked;
            end else begin
                mode = $urandom_range(READY_ALWAYS, READY_RARE);
                seg = $urandom_range(16, 160);
                while (seg > 0 && hold_off_asked == hold_off_served) begin
                    case (mode)
                        READY_ALWAYS: m_tready <= 1'b1;
                        READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                        default:      m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                    seg--;
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                      : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_start();
        // data and last are don't-care on a start item
        send_item(KIND_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_reply();
        int k;
        for (k = 0; k < reply.size(); k++)
            send_item(KIND_BYTE, reply[k], k == reply.size() - 1);
        replies_sent++;
    endtask

    // stop offering items and wait until every verdict is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (verdicts_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_xid(input logic [31:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        xid_now = v;
    endtask

    task automatic fill_to(input int n, input logic pads);
        while (reply.size() < n)
            reply.push_back(pads ? OPT_PAD : 8'($urandom_range(0, 255)));
    endtask

    task automatic make_noise(input int n);
        reply.delete();
        fill_to(n, 1'b0);
    endtask

    task automatic begin_reply(input int fault, input logic [31:0] yiaddr);
        int k;
        make_noise(HEADER_BYTES);
        for (k = 0; k < 4; k++) begin
            reply[4 + k] = xid_now[31 - 8 * k -: 8];
            reply[16 + k] = yiaddr[31 - 8 * k -: 8];
            reply[HEADER_BYTES - 4 + k] = 8'(MAGIC_COOKIE >> (24 - 8 * k));
        end
        k = $urandom_range(0, 3);
        if (fault == FAULT_XID)
            reply[4 + k] = reply[4 + k] ^ 8'($urandom_range(1, 255));
        else if (fault == FAULT_COOKIE)
            reply[HEADER_BYTES - 4 + k] = reply[HEADER_BYTES - 4 + k] ^ 8'($urandom_range(1, 255));
    endtask

    // value bytes start with lead, most significant first, then random filler
    task automatic put_option(input logic [7:0] code, input logic [7:0] size,
                              input logic [31:0] lead);
        int k;
        reply.push_back(code);
        reply.push_back(size);
        for (k = 0; k < size; k++) begin
            if (k < 4)
                reply.push_back(lead[31 - 8 * k -: 8]);
            else
                reply.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic put_type(input logic [7:0] t);
        put_option(OPT_TYPE, 8'd1, {t, 24'h0});
    endtask

    function automatic logic [7:0] random_type();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)
            return TYPE_OFFER;
        if (r < 16)
            return TYPE_ACK;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_reply();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            make_noise(($urandom_range(0, 3) == 0) ? $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 48)
                                                   : $urandom_range(1, HEADER_BYTES - 1));
            return;
        end
        begin_reply(pick < 11 ? FAULT_XID : (pick < 14 ? FAULT_COOKIE : FAULT_NONE), $urandom);
        n = $urandom_range(0, 6);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 6))
                0: put_option(OPT_TYPE, 8'($urandom_range(0, 3)), {random_type(), 24'h0});
                1: put_option(OPT_DNS, 8'($urandom_range(0, 10)), $urandom);
                2: put_option(OPT_MASK, ($urandom_range(0, 1) == 0) ? 8'd4
                                                                    : 8'($urandom_range(0, 8)),
                              $urandom);
                3: put_option(OPT_ROUTER, 8'($urandom_range(0, 12)), $urandom);
                4: fill_to(reply.size() + $urandom_range(1, 5), 1'b1);
                5: put_option(8'($urandom_range(1, 254)), 8'($urandom_range(0, 24)), $urandom);
                default: put_type(random_type());
            endcase
        end
        if ($urandom_range(0, 4) != 0)
            put_type(random_type());
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            reply.push_back(OPT_END);
            fill_to(pick == 0 ? MAX_PAYLOAD : reply.size() + $urandom_range(0, 40), 1'b0);
        end else if (pick < 16) begin
            // no end code: the payload end closes the options
            fill_to(reply.size() + $urandom_range(0, 8), 1'b1);
        end else begin
            // leave the last option unfinished
            n = $urandom_range(1, 20);
            reply.push_back(8'($urandom_range(1, 254)));
            if (pick > 16) begin
                reply.push_back(8'(n));
                fill_to(reply.size() + $urandom_range(0, n - 1), 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] xid_plan[6];
        int ph;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed payloads, id register at its reset value
        send_start();
        begin_reply(FAULT_NONE, 32'h0A00_0001);
        send_reply();
        make_noise(1);
        send_reply();
        make_noise(HEADER_BYTES - 1);
        send_reply();
        make_noise(MAX_PAYLOAD + 1);
        send_reply();
        begin_reply(FAULT_XID, $urandom);
        put_type(TYPE_OFFER);
        put_option(OPT_DNS, 8'd4, $urandom);
        reply.push_back(OPT_END);
        send_reply();
        begin_reply(FAULT_COOKIE, $urandom);
        put_type(TYPE_OFFER);
        put_option(OPT_DNS, 8'd4, $urandom);
        send_reply();
        // first offer, with pads and bytes after the end code
        begin_reply(FAULT_NONE, 32'hFFFF_FFFF);
        fill_to(reply.size() + 3, 1'b1);
        put_type(TYPE_OFFER);
        put_option(OPT_DNS, 8'd8, 32'hFFFF_FFFF);
        put_option(OPT_MASK, 8'd4, 32'hFFFF_FF00);
        put_option(OPT_ROUTER, 8'd4, $urandom);
        reply.push_back(OPT_END);
        fill_to(reply.size() + 20, 1'b0);
        send_reply();
        // a second offer is ignored
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_OFFER);
        reply.push_back(OPT_END);
        send_reply();
        begin_reply(FAULT_NONE, 32'h0);
        put_option(OPT_MASK, 8'd4, 32'hFFFF_FFFF);
        put_option(OPT_ROUTER, 8'd8, 32'hFFFF_FFFF);
        put_option(OPT_DNS, 8'd4, 32'h0);
        put_type(TYPE_ACK);
        send_reply();
        // mask and router too short, empty dns: bound with zero mask and gateway
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_ACK);
        put_option(OPT_MASK, 8'd3, $urandom);
        put_option(OPT_ROUTER, 8'd2, $urandom);
        put_option(OPT_DNS, 8'd0, 32'h0);
        put_option(OPT_MASK, 8'd5, $urandom);
        reply.push_back(OPT_END);
        send_reply();
        // cut right after a code, the earlier dns still counts
        begin_reply(FAULT_NONE, $urandom);
        put_option(OPT_DNS, 8'd4, $urandom);
        put_type(TYPE_ACK);
        reply.push_back(OPT_ROUTER);
        send_reply();
        // cut inside a value, then right after a size
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_ACK);
        reply.push_back(OPT_ROUTER);
        reply.push_back(8'd6);
        fill_to(reply.size() + 2, 1'b0);
        send_reply();
        begin_reply(FAULT_NONE, $urandom);
        reply.push_back(OPT_DNS);
        reply.push_back(8'd255);
        send_reply();
        // type of the wrong size is not taken; of two types the later wins
        begin_reply(FAULT_NONE, $urandom);
        put_option(OPT_TYPE, 8'd2, {TYPE_ACK, TYPE_ACK, 16'h0});
        send_reply();
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_OFFER);
        put_type(TYPE_ACK);
        send_reply();
        // longest payloads: one closed by an end code, one with an option past its end
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_ACK);
        reply.push_back(OPT_END);
        fill_to(MAX_PAYLOAD, 1'b0);
        send_reply();
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_ACK);
        fill_to(MAX_PAYLOAD - 2, 1'b1);
        reply.push_back(OPT_DNS);
        reply.push_back(8'd8);
        send_reply();
        // fresh exchange: an acknowledge without an offer is ignored
        send_start();
        begin_reply(FAULT_NONE, $urandom);
        put_type(TYPE_ACK);
        send_reply();

        // random payloads over several id settings
        xid_plan[0] = 32'h0000_0000;
        xid_plan[1] = 32'hFFFF_FFFF;
        xid_plan[2] = $urandom;
        xid_plan[3] = $urandom;
        xid_plan[4] = XID_RESET;
        xid_plan[5] = $urandom;
        bytes_sent = 0;
        replies_sent = 0;
        for (ph = 0; ph < 6; ph++) begin
            write_xid(xid_plan[ph]);
            if (ph == 1) begin
                // stall the result side while short payloads pile up
                hold_off_asked++;
                repeat (2) @(posedge aclk);
                repeat (12) begin
                    make_noise($urandom_range(1, 3));
                    send_reply();
                end
            end
            while (replies_sent < 10 * (ph + 1) || bytes_sent < 180 * (ph + 1)) begin
                if ($urandom_range(0, 15) == 0)
                    send_start();
                random_reply();
                send_reply();
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
sv/drp_pkg.sv
sv/drp_in_reg.sv
sv/drp_parser.sv
sv/drp_out_reg.sv
sv/dhcp_reply_parser.sv
sv/drp_checker.sv
verif/dhcp_reply_checker.sv
verif/dhcp_reply_parser_test.sv
